FILE: sv/gda_pkg.sv
// Shared types, constants and table functions for the Gregorian date arithmetic block.
`default_nettype none
package gda_pkg;

  localparam int YEAR_W = 14;
  localparam int DIFF_W = 23;
  localparam int JDN_W  = 24;
  localparam int YY_W   = 15;
  localparam int PROD_W = 29;

  // floor(x / 25) == (x * RECIP25) >> RECIP_SH for x below 8192
  localparam logic [15:0] RECIP25  = 16'd41944;
  localparam int          RECIP_SH = 20;

  localparam logic [YY_W-1:0]   YEAR_OFS  = 15'd4800;
  localparam logic [8:0]        DAYS_YEAR = 9'd365;
  localparam logic [YEAR_W-1:0] YEAR_TOP  = 14'd16383;

  localparam logic signed [JDN_W:0] DIFF_HI = 25'sd4194303;
  localparam logic signed [JDN_W:0] DIFF_LO = -25'sd4194304;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_SUM,
    S_M100,
    S_WALK,
    S_FIN
  } gda_state_t;

  typedef struct packed {
    logic load;
    logic do_mul;
    logic do_sum;
    logic do_mod;
    logic do_walk;
    logic do_out;
  } gda_cmd_t;

  typedef struct packed {
    logic is_add;
    logic walk_done;
  } gda_stat_t;

  // month 0 reads as 1, above 12 as 12
  function automatic logic [3:0] fix_month(input logic [3:0] m);
    logic [3:0] r;
    if (m == 4'd0) r = 4'd1;
    else if (m > 4'd12) r = 4'd12;
    else r = m;
    return r;
  endfunction

  function automatic logic [4:0] month_len(input logic [3:0] m, input logic lp);
    logic [4:0] r;
    case (m)
      4'd2:                      r = lp ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:   r = 5'd30;
      default:                   r = 5'd31;
    endcase
    return r;
  endfunction

  // (153 * mm + 2) / 5 with the year starting in March
  function automatic logic [8:0] month_ofs(input logic [3:0] m);
    logic [8:0] r;
    case (m)
      4'd3:    r = 9'd0;
      4'd4:    r = 9'd31;
      4'd5:    r = 9'd61;
      4'd6:    r = 9'd92;
      4'd7:    r = 9'd122;
      4'd8:    r = 9'd153;
      4'd9:    r = 9'd184;
      4'd10:   r = 9'd214;
      4'd11:   r = 9'd245;
      4'd12:   r = 9'd275;
      4'd1:    r = 9'd306;
      4'd2:    r = 9'd337;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

FILE: sv/gda_ctrl.sv
// Controller state machine sequencing the date datapath and owning the result valid.
`default_nettype none
module gda_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  output logic                    out_valid,
  input  wire logic               out_ready,
  input  wire gda_pkg::gda_stat_t stat,
  output gda_pkg::gda_cmd_t       cmd
);

  gda_pkg::gda_state_t state_r, state_nxt;
  logic out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= gda_pkg::S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      gda_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = gda_pkg::S_MUL;
        end
      end
      gda_pkg::S_MUL: begin
        cmd.do_mul = 1'b1;
        state_nxt  = gda_pkg::S_SUM;
      end
      gda_pkg::S_SUM: begin
        cmd.do_sum = 1'b1;
        state_nxt  = stat.is_add ? gda_pkg::S_M100 : gda_pkg::S_FIN;
      end
      gda_pkg::S_M100: begin
        cmd.do_mod = 1'b1;
        state_nxt  = gda_pkg::S_WALK;
      end
      gda_pkg::S_WALK: begin
        if (stat.walk_done) state_nxt = gda_pkg::S_FIN;
        else cmd.do_walk = 1'b1;
      end
      gda_pkg::S_FIN: begin
        // output register free, or its request is taken this cycle
        if (!out_valid_r || out_ready) begin
          cmd.do_out = 1'b1;
          state_nxt  = gda_pkg::S_IDLE;
        end
      end
      default: state_nxt = gda_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    if (cmd.do_out) out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
    else out_valid_nxt = out_valid_r;
  end

  assign out_valid = out_valid_r;

endmodule
`default_nettype wire

FILE: sv/gda_dp.sv
// Datapath: Julian day difference, month walk for day addition, and result registers.
`default_nettype none
module gda_dp #(
  parameter int MAX_ADD_DAYS = 65535
) (
  input  wire logic                 clk,
  input  wire gda_pkg::gda_cmd_t    cmd,
  output gda_pkg::gda_stat_t        stat,
  input  wire logic                 in_kind,
  input  wire logic [4:0]           in_day_a,
  input  wire logic [3:0]           in_month_a,
  input  wire logic [13:0]          in_year_a,
  input  wire logic [4:0]           in_day_b,
  input  wire logic [3:0]           in_month_b,
  input  wire logic [13:0]          in_year_b,
  input  wire logic [15:0]          in_add_count,
  output logic signed [22:0]        out_day_diff,
  output logic                      out_is_before,
  output logic                      out_is_after,
  output logic                      out_is_same,
  output logic [4:0]                out_day_out,
  output logic [3:0]                out_month_out,
  output logic [13:0]               out_year_out
);

  localparam int CNT_W = $clog2(MAX_ADD_DAYS + 1);
  localparam int N_W   = (CNT_W < 16) ? CNT_W : 16;
  localparam int DAY_W = ((N_W > 5) ? N_W : 5) + 1;
  localparam int YW    = gda_pkg::YEAR_W;
  localparam int PW    = gda_pkg::PROD_W;
  localparam int JW    = gda_pkg::JDN_W;
  localparam int SH    = gda_pkg::RECIP_SH;

  // request registers
  logic             kind_r;
  logic [DAY_W-1:0] day_r;
  logic [3:0]       mon_r;
  logic [YW-1:0]    yr_r;
  logic [4:0]       db_r;
  logic [3:0]       mb_r;
  logic [YW-1:0]    yb_r;

  // multiply stage
  logic [23:0] p365a_r, p365b_r;
  logic [PW-1:0] pda_r, pdb_r;
  logic [12:0] q4a_r, q4b_r;
  logic [8:0]  ofsa_r, ofsb_r;

  // sums and leap counters
  logic [JW-1:0] ja_r, jb_r;
  logic [8:0]    c400_r;
  logic [6:0]    c100_r;

  // result registers
  logic signed [22:0] diff_o_r;
  logic               bef_o_r, aft_o_r, same_o_r;
  logic [4:0]         day_o_r;
  logic [3:0]         mon_o_r;
  logic [YW-1:0]      yr_o_r;

  logic [N_W-1:0]     n_clip;
  logic [3:0]         ma_fix;
  logic               a_a, a_b;
  logic [14:0]        yya, yyb;
  logic [12:0]        div_xa;
  logic [8:0]         qa100, qb100;
  logic [JW-1:0]      ja_nxt, jb_nxt;
  logic [5:0]         q400;
  logic [YW-1:0]      r400_full;
  logic [8:0]         c100_pre;
  logic               leap;
  logic [4:0]         lim;
  logic               walk_done;
  logic signed [JW:0] diff;
  logic signed [22:0] diff_sat;

  always_comb begin
    if (32'(in_add_count) > 32'(MAX_ADD_DAYS)) n_clip = N_W'(MAX_ADD_DAYS);
    else n_clip = N_W'(in_add_count);
  end

  assign ma_fix = gda_pkg::fix_month(in_month_a);

  // March-based year: Jan and Feb belong to the year before
  assign a_a = (mon_r <= 4'd2);
  assign a_b = (mb_r <= 4'd2);
  assign yya = 15'(yr_r) + gda_pkg::YEAR_OFS - 15'(a_a);
  assign yyb = 15'(yb_r) + gda_pkg::YEAR_OFS - 15'(a_b);
  assign div_xa = kind_r ? 13'(yr_r >> 4) : 13'(yya >> 2);

  assign qa100 = pda_r[SH+8:SH];
  assign qb100 = pdb_r[SH+8:SH];
  assign ja_nxt = JW'(day_r[4:0]) + JW'(ofsa_r) + JW'(p365a_r) + JW'(q4a_r)
                  - JW'(qa100) + JW'(qa100 >> 2);
  assign jb_nxt = JW'(db_r) + JW'(ofsb_r) + JW'(p365b_r) + JW'(q4b_r)
                  - JW'(qb100) + JW'(qb100 >> 2);

  // year mod 400 from the shared reciprocal product
  assign q400      = pda_r[SH+5:SH];
  assign r400_full = yr_r - (YW'(q400) * YW'(400));

  always_comb begin
    if (c400_r >= 9'd300) c100_pre = c400_r - 9'd300;
    else if (c400_r >= 9'd200) c100_pre = c400_r - 9'd200;
    else if (c400_r >= 9'd100) c100_pre = c400_r - 9'd100;
    else c100_pre = c400_r;
  end

  assign leap      = ((yr_r[1:0] == 2'd0) && (c100_r != 7'd0)) || (c400_r == 9'd0);
  assign lim       = gda_pkg::month_len(mon_r, leap);
  assign walk_done = (day_r <= DAY_W'(lim));

  assign diff = $signed({1'b0, jb_r}) - $signed({1'b0, ja_r});
  always_comb begin
    if (diff > gda_pkg::DIFF_HI) diff_sat = 23'sh3FFFFF;
    else if (diff < gda_pkg::DIFF_LO) diff_sat = -23'sd4194304;
    else diff_sat = diff[22:0];
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind_r <= in_kind;
      day_r  <= DAY_W'(in_day_a) + (in_kind ? DAY_W'(n_clip) : DAY_W'(0));
      mon_r  <= ma_fix;
      yr_r   <= in_year_a;
      db_r   <= in_day_b;
      mb_r   <= gda_pkg::fix_month(in_month_b);
      yb_r   <= in_year_b;
    end
    if (cmd.do_mul) begin
      p365a_r <= 24'(yya) * 24'(gda_pkg::DAYS_YEAR);
      p365b_r <= 24'(yyb) * 24'(gda_pkg::DAYS_YEAR);
      pda_r   <= PW'(div_xa) * PW'(gda_pkg::RECIP25);
      pdb_r   <= PW'(13'(yyb >> 2)) * PW'(gda_pkg::RECIP25);
      q4a_r   <= 13'(yya >> 2);
      q4b_r   <= 13'(yyb >> 2);
      ofsa_r  <= gda_pkg::month_ofs(mon_r);
      ofsb_r  <= gda_pkg::month_ofs(mb_r);
    end
    if (cmd.do_sum) begin
      ja_r   <= ja_nxt;
      jb_r   <= jb_nxt;
      c400_r <= 9'(r400_full);
    end
    if (cmd.do_mod) begin
      c100_r <= 7'(c100_pre);
    end
    if (cmd.do_walk) begin
      day_r <= day_r - DAY_W'(lim);
      if (mon_r == 4'd12) begin
        mon_r <= 4'd1;
        if (yr_r == gda_pkg::YEAR_TOP) begin
          // 14-bit year wraps to zero, which is a multiple of 400
          yr_r   <= '0;
          c100_r <= '0;
          c400_r <= '0;
        end else begin
          yr_r   <= yr_r + 14'd1;
          c100_r <= (c100_r == 7'd99) ? 7'd0 : c100_r + 7'd1;
          c400_r <= (c400_r == 9'd399) ? 9'd0 : c400_r + 9'd1;
        end
      end else begin
        mon_r <= mon_r + 4'd1;
      end
    end
    if (cmd.do_out) begin
      if (kind_r) begin
        diff_o_r <= '0;
        bef_o_r  <= 1'b0;
        aft_o_r  <= 1'b0;
        same_o_r <= 1'b0;
        day_o_r  <= day_r[4:0];
        mon_o_r  <= mon_r;
        yr_o_r   <= yr_r;
      end else begin
        diff_o_r <= diff_sat;
        bef_o_r  <= (diff > 0);
        aft_o_r  <= (diff < 0);
        same_o_r <= (diff == 0);
        day_o_r  <= '0;
        mon_o_r  <= '0;
        yr_o_r   <= '0;
      end
    end
  end

  assign stat.is_add    = kind_r;
  assign stat.walk_done = walk_done;

  assign out_day_diff  = diff_o_r;
  assign out_is_before = bef_o_r;
  assign out_is_after  = aft_o_r;
  assign out_is_same   = same_o_r;
  assign out_day_out   = day_o_r;
  assign out_month_out = mon_o_r;
  assign out_year_out  = yr_o_r;

endmodule
`default_nettype wire

FILE: sv/gregorian_date_arithmetic.sv
// Top level of the Gregorian date arithmetic block: controller plus datapath.
//
//  channel  handshake             payload
//  in       in_valid / in_ready   kind, day/month/year of A and B, add_count
//  out      out_valid / out_ready day_diff, flags, day/month/year out
//
// Compare: request accept, then multiply, sum and finish load the result register.
// Add-days: multiply, sum and mod-100 steps, then one month-walk step per cycle for
// each month crossed, then finish.
// One request at a time; a new request is taken while the last result waits.
// A stalled output holds the finish step until the result register frees.
// Synchronous active-low reset clears the controller and the result valid.
`default_nettype none
module gregorian_date_arithmetic #(
  parameter int MAX_ADD_DAYS = 65535
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire logic          in_kind,
  input  wire logic [4:0]    in_day_a,
  input  wire logic [3:0]    in_month_a,
  input  wire logic [13:0]   in_year_a,
  input  wire logic [4:0]    in_day_b,
  input  wire logic [3:0]    in_month_b,
  input  wire logic [13:0]   in_year_b,
  input  wire logic [15:0]   in_add_count,
  output logic               out_valid,
  input  wire logic          out_ready,
  output logic signed [22:0] out_day_diff,
  output logic               out_is_before,
  output logic               out_is_after,
  output logic               out_is_same,
  output logic [4:0]         out_day_out,
  output logic [3:0]         out_month_out,
  output logic [13:0]        out_year_out
);

  gda_pkg::gda_cmd_t  cmd;
  gda_pkg::gda_stat_t stat;

  gda_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  gda_dp #(
    .MAX_ADD_DAYS (MAX_ADD_DAYS)
  ) u_dp (
    .clk           (clk),
    .cmd           (cmd),
    .stat          (stat),
    .in_kind       (in_kind),
    .in_day_a      (in_day_a),
    .in_month_a    (in_month_a),
    .in_year_a     (in_year_a),
    .in_day_b      (in_day_b),
    .in_month_b    (in_month_b),
    .in_year_b     (in_year_b),
    .in_add_count  (in_add_count),
    .out_day_diff  (out_day_diff),
    .out_is_before (out_is_before),
    .out_is_after  (out_is_after),
    .out_is_same   (out_is_same),
    .out_day_out   (out_day_out),
    .out_month_out (out_month_out),
    .out_year_out  (out_year_out)
  );

endmodule
`default_nettype wire

FILE: dv/gregorian_date_arithmetic_checker.sv
// Date operation codes plus a checker that predicts and compares every date result.
package gda_tb_pkg;

  typedef enum logic {
    OP_COMPARE  = 1'b0,
    OP_ADD_DAYS = 1'b1
  } date_op_t;

endpackage

module gregorian_date_arithmetic_checker #(
  parameter int MAX_ADD_DAYS = 65535
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_ready,
  input  logic              in_kind,
  input  logic [4:0]        in_day_a,
  input  logic [3:0]        in_month_a,
  input  logic [13:0]       in_year_a,
  input  logic [4:0]        in_day_b,
  input  logic [3:0]        in_month_b,
  input  logic [13:0]       in_year_b,
  input  logic [15:0]       in_add_count,
  input  logic              out_valid,
  input  logic              out_ready,
  input  logic signed [22:0] out_day_diff,
  input  logic              out_is_before,
  input  logic              out_is_after,
  input  logic              out_is_same,
  input  logic [4:0]        out_day_out,
  input  logic [3:0]        out_month_out,
  input  logic [13:0]       out_year_out,
  output int                mismatch_count,
  output int                pending_results
);

  localparam longint SPAN_MAX = 64'sd4194303;
  localparam longint SPAN_MIN = -64'sd4194304;

  typedef struct packed {
    logic signed [gda_pkg::DIFF_W-1:0] day_diff;
    logic                              is_before;
    logic                              is_after;
    logic                              is_same;
    logic [4:0]                        day_out;
    logic [3:0]                        month_out;
    logic [gda_pkg::YEAR_W-1:0]        year_out;
  } date_result_t;

  date_result_t awaited_dates[$];

  function automatic int unsigned clamp_month(logic [3:0] m);
    if (m == 4'd0) return 1;
    if (m > 4'd12) return 12;
    return 32'(m);
  endfunction

  // day count on the continuous (Julian) scale, March-based year
  function automatic longint day_number(int unsigned d, int unsigned m, int unsigned y);
    longint a, yy, mm;
    a  = (14 - longint'(m)) / 12;
    yy = longint'(y) + 4800 - a;
    mm = longint'(m) + 12 * a - 3;
    return longint'(d) + (153 * mm + 2) / 5 + 365 * yy + yy / 4 - yy / 100
           + yy / 400 - 32045;
  endfunction

  function automatic date_result_t compute_date_result(
    logic kind, logic [4:0] da, logic [3:0] ma, logic [13:0] ya,
    logic [4:0] db, logic [3:0] mb, logic [13:0] yb, logic [15:0] cnt);
    date_result_t r;
    longint span, sat;
    int unsigned n, day, mon, lim;
    logic [gda_pkg::YEAR_W-1:0] yr;
    r = '0;
    if (kind == gda_tb_pkg::OP_COMPARE) begin
      span = day_number(32'(db), clamp_month(mb), 32'(yb))
             - day_number(32'(da), clamp_month(ma), 32'(ya));
      sat = span;
      if (sat > SPAN_MAX) sat = SPAN_MAX;
      if (sat < SPAN_MIN) sat = SPAN_MIN;
      r.day_diff  = sat[gda_pkg::DIFF_W-1:0];
      r.is_before = (span > 0);
      r.is_after  = (span < 0);
      r.is_same   = (span == 0);
    end else begin
      n = 32'(cnt);
      if (n > MAX_ADD_DAYS) n = MAX_ADD_DAYS;
      day = 32'(da) + n;
      mon = clamp_month(ma);
      yr  = ya;
      while (1) begin
        case (mon)
          2:            lim = ((yr % 4 == 0 && yr % 100 != 0) || yr % 400 == 0) ? 29 : 28;
          4, 6, 9, 11:  lim = 30;
          default:      lim = 31;
        endcase
        if (day <= lim) break;
        day = day - lim;
        mon = mon + 1;
        if (mon > 12) begin
          mon = 1;
          yr  = yr + 14'd1;  // 14-bit year wraps to 0
        end
      end
      r.day_out   = day[4:0];
      r.month_out = mon[3:0];
      r.year_out  = yr;
    end
    return r;
  endfunction

  task automatic report(string what, date_result_t exp, date_result_t got);
    mismatch_count++;
    if (mismatch_count <= 10)
      $display("ERROR %0t: %s; expected diff %0d flags %b%b%b date %0d/%0d/%0d",
               $realtime, what, exp.day_diff, exp.is_before, exp.is_after, exp.is_same,
               exp.day_out, exp.month_out, exp.year_out);
    if (mismatch_count <= 10)
      $display("      got diff %0d flags %b%b%b date %0d/%0d/%0d",
               got.day_diff, got.is_before, got.is_after, got.is_same,
               got.day_out, got.month_out, got.year_out);
  endtask

  task automatic compare_result(date_result_t exp, date_result_t got);
    string bad;
    bad = "";
    if (got.day_diff !== exp.day_diff)   bad = {bad, " day_diff"};
    if (got.is_before !== exp.is_before) bad = {bad, " is_before"};
    if (got.is_after !== exp.is_after)   bad = {bad, " is_after"};
    if (got.is_same !== exp.is_same)     bad = {bad, " is_same"};
    if (got.day_out !== exp.day_out)     bad = {bad, " day_out"};
    if (got.month_out !== exp.month_out) bad = {bad, " month_out"};
    if (got.year_out !== exp.year_out)   bad = {bad, " year_out"};
    if (bad != "") report({"field(s)", bad, " differ"}, exp, got);
  endtask

  always @(posedge clk) begin
    date_result_t got;
    if (rst_n) begin
      if (in_valid && in_ready)
        awaited_dates.push_back(compute_date_result(in_kind, in_day_a, in_month_a, in_year_a,
                                                    in_day_b, in_month_b, in_year_b,
                                                    in_add_count));
      if (out_valid && out_ready) begin
        got.day_diff  = out_day_diff;
        got.is_before = out_is_before;
        got.is_after  = out_is_after;
        got.is_same   = out_is_same;
        got.day_out   = out_day_out;
        got.month_out = out_month_out;
        got.year_out  = out_year_out;
        if (awaited_dates.size() == 0) report("result with no request pending", '0, got);
        else compare_result(awaited_dates.pop_front(), got);
      end
    end
    pending_results <= awaited_dates.size();
  end

endmodule

FILE: dv/gregorian_date_arithmetic_test.sv
// Top of the date arithmetic testbench: clock, reset, request stimulus, stalls and verdict.
module gregorian_date_arithmetic_test;

  localparam int QUIET_LIMIT = 50000;

  typedef struct {
    gda_tb_pkg::date_op_t kind;
    logic [4:0]  day_a;
    logic [3:0]  month_a;
    logic [13:0] year_a;
    logic [4:0]  day_b;
    logic [3:0]  month_b;
    logic [13:0] year_b;
    logic [15:0] add_count;
  } date_request_t;

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_ready;
  logic              in_kind;
  logic [4:0]        in_day_a;
  logic [3:0]        in_month_a;
  logic [13:0]       in_year_a;
  logic [4:0]        in_day_b;
  logic [3:0]        in_month_b;
  logic [13:0]       in_year_b;
  logic [15:0]       in_add_count;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic signed [22:0] out_day_diff;
  logic              out_is_before;
  logic              out_is_after;
  logic              out_is_same;
  logic [4:0]        out_day_out;
  logic [3:0]        out_month_out;
  logic [13:0]       out_year_out;
  int                mismatch_count;
  int                pending_results;

  int idle_pct = 0;
  int stall_pct = 0;
  int quiet_cycles = 0;

  gregorian_date_arithmetic dut (.*);

  gregorian_date_arithmetic_checker checker_i (.*);

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) out_ready <= ($urandom_range(99) >= stall_pct);

  // no request or result moving for too long means the block hung
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("gregorian_date_arithmetic: mismatch");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic date_request_t compare_req(int da, int ma, int ya, int db, int mb, int yb);
    date_request_t r;
    r = '{gda_tb_pkg::OP_COMPARE, 5'(da), 4'(ma), 14'(ya), 5'(db), 4'(mb), 14'(yb), 16'd0};
    return r;
  endfunction

  function automatic date_request_t add_req(int da, int ma, int ya, int cnt);
    date_request_t r;
    r = '{gda_tb_pkg::OP_ADD_DAYS, 5'(da), 4'(ma), 14'(ya), 5'd0, 4'd0, 14'd0, 16'(cnt)};
    return r;
  endfunction

  // mostly legal dates, some raw bit patterns
  function automatic logic [22:0] random_date();
    logic [4:0]  d;
    logic [3:0]  m;
    logic [13:0] y;
    if ($urandom_range(99) < 8) begin
      d = 5'($urandom);
      m = 4'($urandom);
      y = 14'($urandom);
    end else begin
      m = 4'($urandom_range(12, 1));
      d = ($urandom_range(3) == 0) ? 5'($urandom_range(31, 1)) : 5'($urandom_range(28, 1));
      y = 14'($urandom_range(9999, 1));
    end
    return {d, m, y};
  endfunction

  function automatic date_request_t random_request();
    date_request_t r;
    int pick;
    r.kind = ($urandom_range(1) == 1) ? gda_tb_pkg::OP_ADD_DAYS : gda_tb_pkg::OP_COMPARE;
    {r.day_a, r.month_a, r.year_a} = random_date();
    {r.day_b, r.month_b, r.year_b} = random_date();
    pick = $urandom_range(9);
    if (pick < 2) begin
      {r.day_b, r.month_b, r.year_b} = {r.day_a, r.month_a, r.year_a};
    end else if (pick < 4) begin
      r.year_b = 14'(32'(r.year_a) + $urandom_range(2) - 1);
    end
    pick = $urandom_range(99);
    if (pick < 75)      r.add_count = 16'($urandom_range(400, 0));
    else if (pick < 92) r.add_count = 16'($urandom_range(4000, 401));
    else                r.add_count = 16'($urandom);
    return r;
  endfunction

  task automatic send_request(date_request_t r);
    int gap;
    gap = 0;
    while (gap < 60 && $urandom_range(99) < idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_kind      <= r.kind;
    in_day_a     <= r.day_a;
    in_month_a   <= r.month_a;
    in_year_a    <= r.year_a;
    in_day_b     <= r.day_b;
    in_month_b   <= r.month_b;
    in_year_b    <= r.year_b;
    in_add_count <= r.add_count;
    do @(posedge clk); while (!in_ready);
  endtask

  initial begin
    int phase_items[5];
    int phase_idle[5];
    int phase_stall[5];
    phase_items = '{55, 48, 48, 48, 48};
    phase_idle  = '{0, 85, 0, 34, 0};
    phase_stall = '{0, 0, 85, 34, 0};
    rst_n        <= 1'b0;
    in_valid     <= 1'b0;
    in_kind      <= gda_tb_pkg::OP_COMPARE;
    in_day_a     <= '0;
    in_month_a   <= '0;
    in_year_a    <= '0;
    in_day_b     <= '0;
    in_month_b   <= '0;
    in_year_b    <= '0;
    in_add_count <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    send_request(compare_req(29, 2, 2000, 29, 2, 2000));
    send_request(compare_req(1, 1, 1, 31, 12, 9999));
    send_request(compare_req(31, 12, 9999, 1, 1, 1));
    // span wider than the diff field: saturates both ways
    send_request(compare_req(0, 0, 0, 31, 15, 16383));
    send_request(compare_req(31, 15, 16383, 0, 0, 0));
    // Feb 31 lands on Mar 3
    send_request(compare_req(31, 2, 2023, 3, 3, 2023));
    send_request(compare_req(10, 0, 1500, 10, 1, 1500));
    send_request(compare_req(10, 13, 1500, 10, 12, 1500));
    send_request(compare_req(0, 3, 0, 31, 14, 8191));
    send_request(add_req(0, 1, 2020, 0));
    send_request(add_req(31, 2, 2023, 0));
    send_request(add_req(31, 12, 1999, 1));
    send_request(add_req(28, 2, 2000, 1));
    send_request(add_req(28, 2, 1900, 1));
    send_request(add_req(28, 2, 2100, 1));
    send_request(add_req(28, 2, 2024, 1));
    send_request(add_req(1, 1, 1, 65535));
    send_request(add_req(31, 1, 9999, 65535));
    // year counter wraps past its top
    send_request(add_req(31, 12, 16383, 1));
    send_request(add_req(20, 12, 16383, 400));
    send_request(add_req(15, 0, 1800, 10));
    send_request(add_req(15, 13, 1800, 10));
    send_request(add_req(31, 15, 16383, 43690));

    for (int p = 0; p < 5; p++) begin
      idle_pct  <= phase_idle[p];
      stall_pct <= phase_stall[p];
      repeat (phase_items[p]) send_request(random_request());
    end

    in_valid <= 1'b0;
    do @(posedge clk); while (pending_results != 0);
    repeat (12) @(posedge clk);
    if (mismatch_count == 0 && pending_results == 0)
      $display("gregorian_date_arithmetic: match");
    else
      $display("gregorian_date_arithmetic: mismatch");
    $finish;
  end

endmodule
